@@ hw/rtl/lli_pkg.sv @@
// ----------------------------------------------------------------------------
// lli_pkg
// Shared constants, datapath command codes and status bundle for the
// log-log table interpolator.
// ----------------------------------------------------------------------------
package lli_pkg;

    localparam int TABLE_DEPTH = 256;
    localparam int FRAC_BITS   = 16;

    localparam int ADDR_W  = $clog2(TABLE_DEPTH);
    localparam int CNT_W   = $clog2(TABLE_DEPTH + 1);
    localparam int CFG_W   = 9;
    localparam int IDX_W   = 8;
    localparam int TEMP_W  = 21;
    localparam int RATE_W  = 24;
    localparam int VAL_W   = 32;
    localparam int MANT_W  = 16;
    localparam int EXP_W   = 8;
    localparam int KEXP_W  = 5;
    localparam int PROD_W  = (TEMP_W + 1) + (RATE_W + 1);
    localparam int MAG_W   = PROD_W - 1;
    localparam int DCNT_W  = $clog2(MAG_W + 1);
    localparam int LR_W    = RATE_W + 3;
    localparam int FCNT_W  = $clog2(FRAC_BITS + 1);

    localparam logic [MANT_W-1:0] MANT_LO = MANT_W'(1 << (MANT_W - 1));
    localparam logic [MANT_W-1:0] MANT_HI = '1;
    localparam logic [TEMP_W-1:0] MANT_LOG_BASE = TEMP_W'((MANT_W - 1) << FRAC_BITS);
    localparam int EXP_MAX = (1 << (EXP_W - 1)) - 1;
    localparam int EXP_MIN = -(1 << (EXP_W - 1));

    localparam logic OPER_LOAD  = 1'b0;
    localparam logic OPER_QUERY = 1'b1;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_ACCEPT,
        OP_LOGW,
        OP_RD0,
        OP_RDN,
        OP_CHK,
        OP_SADDR,
        OP_SCMP,
        OP_RDI,
        OP_RDIM,
        OP_SEL,
        OP_DEC,
        OP_DIVI,
        OP_DIV,
        OP_DIVF,
        OP_POWI,
        OP_PADDR,
        OP_PLOG,
        OP_OUT
    } t_dp_op;

    typedef struct packed {
        logic query;
        logic temp_zero;
        logic log_done;
        logic oor;
        logic lo_lt_hi;
        logic exact;
        logic t_le;
        logic div_done;
        logic m_lt;
        logic out_free;
    } t_dp_status;

endpackage

@@ hw/rtl/log_log_table_interpolator.sv @@
// Sequence: a load or a zero temperature goes straight to the result register; a query outside the
// table stops after the log2 and the end-node check; an interpolated query runs the log2, the node
// search, the bit-serial divider (skipped on an exact hit or flat pair) and the mantissa search.
// Throughput: one item in flight; the next is accepted once the result register is loaded.
// Reset (synchronous, active low) clears the sequencer and the output valid and sets
// the node count to 2; the node tables are not cleared.
// ----------------------------------------------------------------------------
// log_log_table_interpolator
// Log-log piecewise-linear table lookup with a power-of-two result.
// ----------------------------------------------------------------------------
module log_log_table_interpolator
    import lli_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_in_valid,
    output logic                     o_in_stall,
    input  logic                     i_operation,
    input  logic [IDX_W-1:0]         i_node_index,
    input  logic [TEMP_W-1:0]        i_node_log_temp,
    input  logic signed [RATE_W-1:0] i_node_log_rate,
    input  logic [VAL_W-1:0]         i_temperature,
    input  logic                     i_cfg_valid,
    output logic                     o_cfg_ready,
    input  logic [CFG_W-1:0]         i_cfg_data,
    output logic                     o_out_valid,
    input  logic                     i_out_stall,
    output logic                     o_in_range,
    output logic [MANT_W-1:0]        o_rate_mantissa,
    output logic signed [EXP_W-1:0]  o_rate_exponent
);

    t_dp_op     op;
    t_dp_status status;

    assign o_cfg_ready = 1'b1;

    lli_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_status   (status),
        .o_op       (op),
        .o_in_stall (o_in_stall)
    );

    lli_dp u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_op            (op),
        .i_operation     (i_operation),
        .i_node_index    (i_node_index),
        .i_node_log_temp (i_node_log_temp),
        .i_node_log_rate (i_node_log_rate),
        .i_temperature   (i_temperature),
        .i_cfg_valid     (i_cfg_valid),
        .i_cfg_data      (i_cfg_data),
        .i_out_stall     (i_out_stall),
        .o_status        (status),
        .o_out_valid     (o_out_valid),
        .o_in_range      (o_in_range),
        .o_rate_mantissa (o_rate_mantissa),
        .o_rate_exponent (o_rate_exponent)
    );

endmodule

@@ hw/rtl/lli_ram.sv @@
// ----------------------------------------------------------------------------
// lli_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module lli_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ hw/rtl/lli_log2.sv @@
// ----------------------------------------------------------------------------
// lli_log2
// Iterative base-2 logarithm: leading-one position plus fraction bits from
// one squaring step per cycle.
// ----------------------------------------------------------------------------
module lli_log2
    import lli_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [VAL_W-1:0]  i_value,
    output logic              o_done,
    output logic [TEMP_W-1:0] o_result
);

    logic                 r_busy, n_busy;
    logic                 r_done, n_done;
    logic [FCNT_W-1:0]    r_cnt, n_cnt;
    logic [KEXP_W-1:0]    r_k, n_k;
    logic [VAL_W-1:0]     r_y, n_y;
    logic [FRAC_BITS-1:0] r_frac, n_frac;

    logic [KEXP_W-1:0]    msb;
    logic [2*VAL_W-1:0]   sq;
    logic [VAL_W:0]       sq_top;

    always_comb begin
        msb = '0;
        for (int i = 0; i < VAL_W; i++) begin
            if (i_value[i]) begin
                msb = KEXP_W'(i);
            end
        end
    end

    assign sq     = (2*VAL_W)'(r_y) * (2*VAL_W)'(r_y);
    assign sq_top = sq[2*VAL_W-1:VAL_W-1];

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_k    = r_k;
        n_y    = r_y;
        n_frac = r_frac;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = '0;
            n_k    = msb;
            n_y    = i_value << (KEXP_W'(VAL_W - 1) - msb);
            n_frac = '0;
        end else if (r_busy) begin
            // A square at or above two contributes a one bit and renormalizes.
            if (sq_top[VAL_W]) begin
                n_y    = sq_top[VAL_W:1];
                n_frac = {r_frac[FRAC_BITS-2:0], 1'b1};
            end else begin
                n_y    = sq_top[VAL_W-1:0];
                n_frac = {r_frac[FRAC_BITS-2:0], 1'b0};
            end
            n_cnt = r_cnt + 1'b1;
            if (r_cnt == FCNT_W'(FRAC_BITS - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
        r_cnt  <= n_cnt;
        r_k    <= n_k;
        r_y    <= n_y;
        r_frac <= n_frac;
    end

    assign o_done   = r_done;
    assign o_result = TEMP_W'({r_k, r_frac});

endmodule

@@ hw/rtl/lli_dp.sv @@
// ----------------------------------------------------------------------------
// lli_dp
// Datapath: node tables, log2 unit, node search registers, interpolation
// multiply, bit-serial divider, mantissa search and the output register.
// ----------------------------------------------------------------------------
module lli_dp
    import lli_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  t_dp_op                   i_op,
    input  logic                     i_operation,
    input  logic [IDX_W-1:0]         i_node_index,
    input  logic [TEMP_W-1:0]        i_node_log_temp,
    input  logic signed [RATE_W-1:0] i_node_log_rate,
    input  logic [VAL_W-1:0]         i_temperature,
    input  logic                     i_cfg_valid,
    input  logic [CFG_W-1:0]         i_cfg_data,
    input  logic                     i_out_stall,
    output t_dp_status               o_status,
    output logic                     o_out_valid,
    output logic                     o_in_range,
    output logic [MANT_W-1:0]        o_rate_mantissa,
    output logic signed [EXP_W-1:0]  o_rate_exponent
);

    logic [CFG_W-1:0]         r_entry_count;
    logic [CNT_W-1:0]         eff_count;

    logic [TEMP_W-1:0]        r_x;
    logic [CNT_W-1:0]         r_lo, r_hi;
    logic [ADDR_W-1:0]        r_idx;
    logic [TEMP_W-1:0]        r_t0, r_t1;
    logic signed [RATE_W-1:0] r_r0, r_r1;
    logic signed [PROD_W-1:0] r_prod;
    logic                     r_neg;
    logic [MAG_W-1:0]         r_dvd, r_quo;
    logic [TEMP_W-1:0]        r_rem, r_dsr;
    logic [DCNT_W-1:0]        r_dcnt;
    logic signed [LR_W-1:0]   r_lr;
    logic [TEMP_W-1:0]        r_limit;
    logic [MANT_W-1:0]        r_mlo, r_mhi, r_mmid;

    logic                     r_res_inr;
    logic [MANT_W-1:0]        r_res_mant;
    logic signed [EXP_W-1:0]  r_res_exp;
    logic                     r_out_valid;
    logic                     r_out_inr;
    logic [MANT_W-1:0]        r_out_mant;
    logic signed [EXP_W-1:0]  r_out_exp;

    logic                     we;
    logic [ADDR_W-1:0]        raddr;
    logic [TEMP_W-1:0]        temp_q;
    logic signed [RATE_W-1:0] rate_q;

    logic                     log_start;
    logic [VAL_W-1:0]         log_value;
    logic                     log_done;
    logic [TEMP_W-1:0]        log_res;

    logic [CNT_W:0]           s_sum;
    logic [CNT_W-1:0]         s_mid;
    logic [CNT_W-1:0]         idx_c;
    logic [MANT_W:0]          m_sum;
    logic [MANT_W-1:0]        m_mid;
    logic [TEMP_W:0]          rem_sh;
    logic [TEMP_W-1:0]        temp_diff;
    logic signed [RATE_W:0]   rate_diff;
    logic signed [PROD_W-1:0] prod_c;
    logic [MAG_W-1:0]         mag_c;
    logic signed [LR_W-1:0]   quo_s;
    logic signed [LR_W-1:0]   exp_full;

    always_comb begin
        if (r_entry_count < CFG_W'(2)) begin
            eff_count = CNT_W'(2);
        end else if (32'(r_entry_count) > TABLE_DEPTH) begin
            eff_count = CNT_W'(TABLE_DEPTH);
        end else begin
            eff_count = CNT_W'(r_entry_count);
        end
    end

    assign s_sum = (CNT_W+1)'(r_lo) + (CNT_W+1)'(r_hi);
    assign s_mid = s_sum[CNT_W:1];
    assign m_sum = (MANT_W+1)'(r_mlo) + (MANT_W+1)'(r_mhi) + 1'b1;
    assign m_mid = m_sum[MANT_W:1];

    always_comb begin
        if (r_lo == '0) begin
            idx_c = CNT_W'(1);
        end else if (r_lo > eff_count - 1'b1) begin
            idx_c = eff_count - 1'b1;
        end else begin
            idx_c = r_lo;
        end
    end

    assign we = (i_op == OP_ACCEPT) && (i_operation == OPER_LOAD)
                && (32'(i_node_index) < TABLE_DEPTH);

    always_comb begin
        case (i_op)
            OP_RDN:   raddr = ADDR_W'(eff_count - 1'b1);
            OP_SADDR: raddr = ADDR_W'(s_mid);
            OP_RDI:   raddr = ADDR_W'(idx_c);
            OP_RDIM:  raddr = r_idx - 1'b1;
            default:  raddr = '0;
        endcase
    end

    lli_ram #(.WIDTH(TEMP_W), .DEPTH(TABLE_DEPTH)) u_temp_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (ADDR_W'(i_node_index)),
        .i_wdata (i_node_log_temp),
        .i_raddr (raddr),
        .o_rdata (temp_q)
    );

    lli_ram #(.WIDTH(RATE_W), .DEPTH(TABLE_DEPTH)) u_rate_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (ADDR_W'(i_node_index)),
        .i_wdata (i_node_log_rate),
        .i_raddr (raddr),
        .o_rdata (rate_q)
    );

    assign log_start = ((i_op == OP_ACCEPT) && (i_operation == OPER_QUERY))
                       || ((i_op == OP_PADDR) && (r_mlo < r_mhi));
    assign log_value = (i_op == OP_ACCEPT) ? i_temperature : VAL_W'(m_mid);

    lli_log2 u_log2 (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (log_start),
        .i_value  (log_value),
        .o_done   (log_done),
        .o_result (log_res)
    );

    // Both multiplier operands are one bit wider, so the signed product never wraps.
    assign temp_diff = r_x - r_t0;
    assign rate_diff = {r_r1[RATE_W-1], r_r1} - {r_r0[RATE_W-1], r_r0};
    assign prod_c = PROD_W'($signed({1'b0, temp_diff})) * PROD_W'(rate_diff);
    assign mag_c  = r_prod[PROD_W-1] ? MAG_W'(-r_prod) : MAG_W'(r_prod);
    assign rem_sh = {r_rem, r_dvd[MAG_W-1]};
    assign quo_s  = $signed(r_quo[LR_W-1:0]);
    assign exp_full = r_lr >>> FRAC_BITS;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entry_count <= CFG_W'(2);
            r_out_valid   <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_entry_count <= i_cfg_data;
            end
            if (i_op == OP_OUT) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end

        case (i_op)
            OP_ACCEPT: begin
                r_res_inr  <= 1'b0;
                r_res_mant <= '0;
                r_res_exp  <= '0;
            end
            OP_LOGW: begin
                if (log_done) begin
                    r_x <= log_res;
                end
            end
            OP_RDN: begin
                r_t0 <= temp_q;
            end
            OP_CHK: begin
                r_lo <= '0;
                r_hi <= eff_count;
            end
            OP_SCMP: begin
                if (temp_q < r_x) begin
                    r_lo <= CNT_W'(r_idx) + 1'b1;
                end else begin
                    r_hi <= CNT_W'(r_idx);
                end
            end
            OP_SADDR: begin
                r_idx <= ADDR_W'(s_mid);
            end
            OP_RDI: begin
                r_idx <= ADDR_W'(idx_c);
            end
            OP_RDIM: begin
                r_t1 <= temp_q;
                r_r1 <= rate_q;
            end
            OP_SEL: begin
                r_t0 <= temp_q;
                r_r0 <= rate_q;
            end
            OP_DEC: begin
                r_prod <= prod_c;
                // An exact node hit takes that node's rate; a flat pair takes the lower.
                if (r_t1 == r_x) begin
                    r_lr <= LR_W'(r_r1);
                end else begin
                    r_lr <= LR_W'(r_r0);
                end
            end
            OP_DIVI: begin
                r_neg  <= r_prod[PROD_W-1];
                r_dvd  <= mag_c;
                r_quo  <= '0;
                r_rem  <= '0;
                r_dsr  <= r_t1 - r_t0;
                r_dcnt <= '0;
            end
            OP_DIV: begin
                if (r_dcnt != DCNT_W'(MAG_W)) begin
                    if (rem_sh >= (TEMP_W+1)'(r_dsr)) begin
                        r_rem <= TEMP_W'(rem_sh - (TEMP_W+1)'(r_dsr));
                        r_quo <= {r_quo[MAG_W-2:0], 1'b1};
                    end else begin
                        r_rem <= rem_sh[TEMP_W-1:0];
                        r_quo <= {r_quo[MAG_W-2:0], 1'b0};
                    end
                    r_dvd  <= r_dvd << 1;
                    r_dcnt <= r_dcnt + 1'b1;
                end
            end
            OP_DIVF: begin
                r_lr <= LR_W'(r_r0) + (r_neg ? -quo_s : quo_s);
            end
            OP_POWI: begin
                r_mlo   <= MANT_LO;
                r_mhi   <= MANT_HI;
                r_limit <= MANT_LOG_BASE + TEMP_W'(r_lr[FRAC_BITS-1:0]);
                if (exp_full > LR_W'(EXP_MAX)) begin
                    r_res_exp <= EXP_W'(EXP_MAX);
                end else if (exp_full < LR_W'(EXP_MIN)) begin
                    r_res_exp <= EXP_W'(EXP_MIN);
                end else begin
                    r_res_exp <= EXP_W'(exp_full);
                end
            end
            OP_PADDR: begin
                r_mmid <= m_mid;
                if (!(r_mlo < r_mhi)) begin
                    r_res_inr  <= 1'b1;
                    r_res_mant <= r_mlo;
                end
            end
            OP_PLOG: begin
                if (log_done) begin
                    if (log_res <= r_limit) begin
                        r_mlo <= r_mmid;
                    end else begin
                        r_mhi <= r_mmid - 1'b1;
                    end
                end
            end
            OP_OUT: begin
                r_out_inr  <= r_res_inr;
                r_out_mant <= r_res_mant;
                r_out_exp  <= r_res_exp;
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        o_status.query     = (i_operation == OPER_QUERY);
        o_status.temp_zero = (i_temperature == '0);
        o_status.log_done  = log_done;
        o_status.oor       = (r_x <= r_t0) || (r_x >= temp_q);
        o_status.lo_lt_hi  = (r_lo < r_hi);
        o_status.exact     = (r_t1 == r_x);
        o_status.t_le      = (r_t1 <= r_t0);
        o_status.div_done  = (r_dcnt == DCNT_W'(MAG_W));
        o_status.m_lt      = (r_mlo < r_mhi);
        o_status.out_free  = !r_out_valid || !i_out_stall;
    end

    assign o_out_valid     = r_out_valid;
    assign o_in_range      = r_out_inr;
    assign o_rate_mantissa = r_out_mant;
    assign o_rate_exponent = r_out_exp;

endmodule

@@ hw/rtl/lli_ctrl.sv @@
// ----------------------------------------------------------------------------
// lli_ctrl
// Sequencer that steps the datapath through load, log2, node search,
// interpolation, division and mantissa search for one item at a time.
// ----------------------------------------------------------------------------
module lli_ctrl
    import lli_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  t_dp_status i_status,
    output t_dp_op     o_op,
    output logic       o_in_stall
);

    typedef enum logic [17:0] {
        S_IDLE  = 18'h00001,
        S_LOG   = 18'h00002,
        S_RD0   = 18'h00004,
        S_RDN   = 18'h00008,
        S_CHK   = 18'h00010,
        S_SRCH  = 18'h00020,
        S_SCMP  = 18'h00040,
        S_RDI   = 18'h00080,
        S_RDIM  = 18'h00100,
        S_SEL   = 18'h00200,
        S_DEC   = 18'h00400,
        S_DIVI  = 18'h00800,
        S_DIV   = 18'h01000,
        S_DIVF  = 18'h02000,
        S_POWI  = 18'h04000,
        S_PSRCH = 18'h08000,
        S_PLOG  = 18'h10000,
        S_FIN   = 18'h20000
    } t_state;

    t_state r_state, n_state;

    always_comb begin
        n_state = r_state;
        o_op    = OP_NONE;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_op = OP_ACCEPT;
                    if (i_status.query && !i_status.temp_zero) begin
                        n_state = S_LOG;
                    end else begin
                        n_state = S_FIN;
                    end
                end
            end
            S_LOG: begin
                o_op = OP_LOGW;
                if (i_status.log_done) begin
                    n_state = S_RD0;
                end
            end
            S_RD0: begin
                o_op    = OP_RD0;
                n_state = S_RDN;
            end
            S_RDN: begin
                o_op    = OP_RDN;
                n_state = S_CHK;
            end
            S_CHK: begin
                o_op    = OP_CHK;
                n_state = i_status.oor ? S_FIN : S_SRCH;
            end
            S_SRCH: begin
                if (i_status.lo_lt_hi) begin
                    o_op    = OP_SADDR;
                    n_state = S_SCMP;
                end else begin
                    o_op    = OP_RDI;
                    n_state = S_RDIM;
                end
            end
            S_SCMP: begin
                o_op    = OP_SCMP;
                n_state = S_SRCH;
            end
            S_RDI: begin
                o_op    = OP_RDI;
                n_state = S_RDIM;
            end
            S_RDIM: begin
                o_op    = OP_RDIM;
                n_state = S_SEL;
            end
            S_SEL: begin
                o_op    = OP_SEL;
                n_state = S_DEC;
            end
            S_DEC: begin
                o_op = OP_DEC;
                if (i_status.exact || i_status.t_le) begin
                    n_state = S_POWI;
                end else begin
                    n_state = S_DIVI;
                end
            end
            S_DIVI: begin
                o_op    = OP_DIVI;
                n_state = S_DIV;
            end
            S_DIV: begin
                o_op = OP_DIV;
                if (i_status.div_done) begin
                    n_state = S_DIVF;
                end
            end
            S_DIVF: begin
                o_op    = OP_DIVF;
                n_state = S_POWI;
            end
            S_POWI: begin
                o_op    = OP_POWI;
                n_state = S_PSRCH;
            end
            S_PSRCH: begin
                o_op    = OP_PADDR;
                n_state = i_status.m_lt ? S_PLOG : S_FIN;
            end
            S_PLOG: begin
                o_op = OP_PLOG;
                if (i_status.log_done) begin
                    n_state = S_PSRCH;
                end
            end
            S_FIN: begin
                if (i_status.out_free) begin
                    o_op    = OP_OUT;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_stall = (r_state != S_IDLE);

endmodule

@@ hw/rtl/lli_checker.sv @@
// ----------------------------------------------------------------------------
// lli_port_checker
// Port-level checks for the log-log table interpolator.
// ----------------------------------------------------------------------------
module lli_port_checker
    import lli_pkg::*;
(
    input logic                     i_clk,
    input logic                     i_rst_n,
    input logic                     o_out_valid,
    input logic                     i_out_stall,
    input logic                     o_in_range,
    input logic [MANT_W-1:0]        o_rate_mantissa,
    input logic signed [EXP_W-1:0]  o_rate_exponent
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("result dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> $stable(o_rate_mantissa) && $stable(o_in_range))
        else $error("stalled result changed");

    a_out_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_in_range |-> o_rate_mantissa == '0 && o_rate_exponent == '0)
        else $error("out-of-range item has nonzero fields");

    a_mant_norm: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_in_range |-> o_rate_mantissa[MANT_W-1])
        else $error("in-range mantissa not normalized");

endmodule

bind log_log_table_interpolator lli_port_checker u_lli_port_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_out_valid     (o_out_valid),
    .i_out_stall     (i_out_stall),
    .o_in_range      (o_in_range),
    .o_rate_mantissa (o_rate_mantissa),
    .o_rate_exponent (o_rate_exponent)
);
